>>> hdl/pdv_pkg.sv
// ----------------------------------------------------------------------------
// pdv_pkg
// Shared widths, register indexes and pipeline record types for the
// perspective divide and viewport transform core.
// ----------------------------------------------------------------------------
package pdv_pkg;

  // Coordinate word width (signed fixed point)
  localparam int COORD_W = 32;
  // Viewport size register width
  localparam int SIZE_W  = 14;
  // APB data and address widths
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // Quotient bits produced by the long division (one per stage)
  localparam int QUO_W   = 33;
  // Partial remainder width
  localparam int REM_W   = 33;

  // Register stages: front, one per quotient bit, saturate, multiply, clamp
  localparam int NSTAGE  = QUO_W + 4;

  // Register indexes (byte address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One dividend lane in flight through the divider
  typedef struct packed {
    logic               neg;   // quotient sign
    logic               ovf;   // quotient known to reach 2^33
    logic [REM_W-1:0]   rem;   // partial remainder
    logic [QUO_W-1:0]   quo;   // quotient bits so far
    logic [COORD_W-1:0] ma;    // dividend magnitude
  } lane_t;

  // Three lanes (x, y, z) sharing the divisor
  typedef struct packed {
    lane_t [2:0]        lane;
    logic [COORD_W-1:0] mw;    // divisor magnitude
    logic               wz;    // w was zero
  } div_pipe_t;

endpackage

>>> hdl/pdv_if.sv
// ----------------------------------------------------------------------------
// pdv_if
// Valid/ready channels: clip-space vertex in, screen-space result out.
// ----------------------------------------------------------------------------
interface pdv_vtx_if;
  logic                                valid;
  logic                                ready;
  logic signed [pdv_pkg::COORD_W-1:0]  clip_x;
  logic signed [pdv_pkg::COORD_W-1:0]  clip_y;
  logic signed [pdv_pkg::COORD_W-1:0]  clip_z;
  logic signed [pdv_pkg::COORD_W-1:0]  clip_w;

  modport source (output valid, clip_x, clip_y, clip_z, clip_w, input ready);
  modport sink   (input valid, clip_x, clip_y, clip_z, clip_w, output ready);
endinterface

interface pdv_scr_if;
  logic                                valid;
  logic                                ready;
  logic signed [pdv_pkg::COORD_W-1:0]  screen_x;
  logic signed [pdv_pkg::COORD_W-1:0]  screen_y;
  logic signed [pdv_pkg::COORD_W-1:0]  ndc_depth;
  logic                                w_zero;
  logic                                saturated;

  modport source (output valid, screen_x, screen_y, ndc_depth, w_zero, saturated,
                  input ready);
  modport sink   (input valid, screen_x, screen_y, ndc_depth, w_zero, saturated,
                  output ready);
endinterface

>>> hdl/pdv_cfg.sv
// ----------------------------------------------------------------------------
// pdv_cfg
// APB register file holding the viewport width and height.
// ----------------------------------------------------------------------------
module pdv_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdv_pkg::APB_AW-1:0]  paddr,
  input  logic [pdv_pkg::APB_DW-1:0]  pwdata,
  output logic [pdv_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [pdv_pkg::SIZE_W-1:0]  width,
  output logic [pdv_pkg::SIZE_W-1:0]  height
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // Write on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= pdv_pkg::SIZE_W'(640);
      height <= pdv_pkg::SIZE_W'(480);
    end else if (wr) begin
      case (paddr[2])
        pdv_pkg::REG_WIDTH:  width  <= pwdata[pdv_pkg::SIZE_W-1:0];
        pdv_pkg::REG_HEIGHT: height <= pwdata[pdv_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      pdv_pkg::REG_WIDTH:  prdata = pdv_pkg::APB_DW'(width);
      pdv_pkg::REG_HEIGHT: prdata = pdv_pkg::APB_DW'(height);
      default:             prdata = '0;
    endcase
  end

endmodule

>>> hdl/pdv_div_front.sv
// ----------------------------------------------------------------------------
// pdv_div_front
// Divider entry stage: magnitudes, quotient signs, early overflow check and
// the starting partial remainder for the x, y and z lanes.
// ----------------------------------------------------------------------------
module pdv_div_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [pdv_pkg::COORD_W-1:0] clip_x,
  input  logic signed [pdv_pkg::COORD_W-1:0] clip_y,
  input  logic signed [pdv_pkg::COORD_W-1:0] clip_z,
  input  logic signed [pdv_pkg::COORD_W-1:0] clip_w,
  output pdv_pkg::div_pipe_t                 q
);

  // Dividend bits above this position are consumed before the first step
  localparam int PRE_SHIFT = pdv_pkg::QUO_W - FRAC_BITS;

  logic [pdv_pkg::COORD_W-1:0] a     [3];
  logic [pdv_pkg::COORD_W-1:0] ma    [3];
  logic [pdv_pkg::COORD_W-1:0] top   [3];
  logic [pdv_pkg::COORD_W-1:0] mw;
  pdv_pkg::div_pipe_t          q_next;

  assign a[0] = clip_x;
  assign a[1] = clip_y;
  assign a[2] = clip_z;

  // Take magnitudes and test for a quotient of 2^33 or more
  always_comb begin
    mw = clip_w[pdv_pkg::COORD_W-1] ? (~clip_w + 1'b1) : clip_w;
    q_next.mw = mw;
    q_next.wz = (clip_w == '0);
    for (int l = 0; l < 3; l++) begin
      ma[l]  = a[l][pdv_pkg::COORD_W-1] ? (~a[l] + 1'b1) : a[l];
      top[l] = ma[l] >> PRE_SHIFT;
      q_next.lane[l].neg = a[l][pdv_pkg::COORD_W-1] ^ clip_w[pdv_pkg::COORD_W-1];
      q_next.lane[l].ovf = (top[l] >= mw);
      q_next.lane[l].rem = pdv_pkg::REM_W'(top[l]);
      q_next.lane[l].quo = '0;
      q_next.lane[l].ma  = ma[l];
    end
  end

  // Hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

>>> hdl/pdv_div_stage.sv
// ----------------------------------------------------------------------------
// pdv_div_stage
// One restoring division step for the three lanes: shift in the next
// dividend bit, trial subtract the divisor, keep one quotient bit.
// ----------------------------------------------------------------------------
module pdv_div_stage #(
  parameter int FRAC_BITS = 16,
  parameter int BIT       = 32
) (
  input  logic               clk,
  input  logic               en,
  input  pdv_pkg::div_pipe_t d,
  output pdv_pkg::div_pipe_t q
);

  // Dividend is magnitude shifted left by FRAC_BITS: low bits are zero
  localparam bit NBIT_ON  = (BIT >= FRAC_BITS);
  localparam int NBIT_IDX = NBIT_ON ? (BIT - FRAC_BITS) : 0;

  logic [pdv_pkg::REM_W-1:0] rin  [3];
  logic [pdv_pkg::REM_W:0]   diff [3];
  logic                      nbit [3];
  pdv_pkg::div_pipe_t        q_next;

  // Trial subtract per lane
  always_comb begin
    q_next = d;
    for (int l = 0; l < 3; l++) begin
      nbit[l] = NBIT_ON ? d.lane[l].ma[NBIT_IDX] : 1'b0;
      rin[l]  = {d.lane[l].rem[pdv_pkg::REM_W-2:0], nbit[l]};
      diff[l] = {1'b0, rin[l]} - {2'b00, d.mw};
      q_next.lane[l].rem = diff[l][pdv_pkg::REM_W] ? rin[l]
                                                   : diff[l][pdv_pkg::REM_W-1:0];
      q_next.lane[l].quo = {d.lane[l].quo[pdv_pkg::QUO_W-2:0], ~diff[l][pdv_pkg::REM_W]};
    end
  end

  // Hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

>>> hdl/pdv_map.sv
// ----------------------------------------------------------------------------
// pdv_map
// Back end: sign and saturate the quotients, scale NDC x and y by the
// viewport size, then halve toward zero and clamp to the 32-bit range.
// ----------------------------------------------------------------------------
module pdv_map #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               en_sat,
  input  logic                               en_mul,
  input  logic                               en_out,
  input  pdv_pkg::div_pipe_t                 d,
  input  logic [pdv_pkg::SIZE_W-1:0]         width,
  input  logic [pdv_pkg::SIZE_W-1:0]         height,
  output logic signed [pdv_pkg::COORD_W-1:0] screen_x,
  output logic signed [pdv_pkg::COORD_W-1:0] screen_y,
  output logic signed [pdv_pkg::COORD_W-1:0] ndc_depth,
  output logic                               w_zero,
  output logic                               saturated
);

  localparam int SUM_W  = pdv_pkg::COORD_W + 1;
  localparam int PROD_W = SUM_W + pdv_pkg::SIZE_W + 1;

  localparam logic [pdv_pkg::QUO_W-1:0] QPOS_MAX = pdv_pkg::QUO_W'(33'h0_7FFF_FFFF);
  localparam logic [pdv_pkg::QUO_W-1:0] QNEG_MAG = pdv_pkg::QUO_W'(33'h0_8000_0000);
  localparam logic signed [pdv_pkg::COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [pdv_pkg::COORD_W-1:0] CMIN = 32'sh8000_0000;
  localparam logic signed [SUM_W-1:0]  ONE  = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] PMAX = PROD_W'(CMAX);
  localparam logic signed [PROD_W-1:0] PMIN = PROD_W'(CMIN);

  // Saturate stage registers
  logic signed [pdv_pkg::COORD_W-1:0] ndc      [3];
  logic signed [pdv_pkg::COORD_W-1:0] ndc_next [3];
  logic                               lsat     [3];
  logic                               s_wz;
  logic                               s_sat;

  // Multiply stage registers
  logic signed [PROD_W-1:0]           px;
  logic signed [PROD_W-1:0]           py;
  logic signed [pdv_pkg::COORD_W-1:0] m_nz;
  logic                               m_wz;
  logic                               m_sat;

  // Clamp stage logic
  logic signed [SUM_W-1:0]            sum_x;
  logic signed [SUM_W-1:0]            sum_y;
  logic signed [PROD_W-1:0]           hx;
  logic signed [PROD_W-1:0]           hy;
  logic signed [pdv_pkg::COORD_W-1:0] sx_next;
  logic signed [pdv_pkg::COORD_W-1:0] sy_next;
  logic                               cx;
  logic                               cy;

  // Apply quotient sign and clamp to the NDC range
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (d.lane[l].neg) begin
        lsat[l]     = d.lane[l].ovf | (d.lane[l].quo > QNEG_MAG);
        ndc_next[l] = lsat[l] ? CMIN
                              : pdv_pkg::COORD_W'(~d.lane[l].quo + 1'b1);
      end else begin
        lsat[l]     = d.lane[l].ovf | (d.lane[l].quo > QPOS_MAX);
        ndc_next[l] = lsat[l] ? CMAX : pdv_pkg::COORD_W'(d.lane[l].quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sat) begin
      for (int l = 0; l < 3; l++) begin
        ndc[l] <= ndc_next[l];
      end
      s_wz  <= d.wz;
      s_sat <= ~d.wz & (lsat[0] | lsat[1] | lsat[2]);
    end
  end

  // Scale (ndc + 1.0) by the viewport size
  assign sum_x = $signed({ndc[0][pdv_pkg::COORD_W-1], ndc[0]}) + ONE;
  assign sum_y = $signed({ndc[1][pdv_pkg::COORD_W-1], ndc[1]}) + ONE;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      px    <= sum_x * $signed({1'b0, width});
      py    <= sum_y * $signed({1'b0, height});
      m_nz  <= ndc[2];
      m_wz  <= s_wz;
      m_sat <= s_sat;
    end
  end

  // Halve toward zero and clamp
  always_comb begin
    hx = (px + $signed(PROD_W'(px[PROD_W-1]))) >>> 1;
    hy = (py + $signed(PROD_W'(py[PROD_W-1]))) >>> 1;
    cx = (hx > PMAX) | (hx < PMIN);
    cy = (hy > PMAX) | (hy < PMIN);
    if (hx > PMAX) begin
      sx_next = CMAX;
    end else if (hx < PMIN) begin
      sx_next = CMIN;
    end else begin
      sx_next = hx[pdv_pkg::COORD_W-1:0];
    end
    if (hy > PMAX) begin
      sy_next = CMAX;
    end else if (hy < PMIN) begin
      sy_next = CMIN;
    end else begin
      sy_next = hy[pdv_pkg::COORD_W-1:0];
    end
  end

  // Output register: force zero when w was zero
  always_ff @(posedge clk) begin
    if (en_out) begin
      screen_x  <= m_wz ? '0 : sx_next;
      screen_y  <= m_wz ? '0 : sy_next;
      ndc_depth <= m_wz ? '0 : m_nz;
      w_zero    <= m_wz;
      saturated <= ~m_wz & (m_sat | cx | cy);
    end
  end

endmodule

>>> hdl/perspective_divide_viewport_core.sv
// ----------------------------------------------------------------------------
// perspective_divide_viewport_core
// Clip-space vertex to screen coordinates: divide by w, map to viewport.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake        | Payload
//  vtx     | in  | valid / ready    | clip_x, clip_y, clip_z, clip_w
//  scr     | out | valid / ready    | screen_x, screen_y, ndc_depth, w_zero, saturated
//  apb     | in  | psel/penable     | paddr, pwdata, prdata (width @0, height @4)
//
//  One vertex per cycle sustained while scr.ready is high; stages: an entry stage, one
//  restoring division step per quotient bit (33 stages, three lanes sharing w),
//  then saturate, size multiply and clamp/output stages.
//  Reset clears stage valid bits and sets the viewport to 640 x 480.
//  A stall holds only the stages that are full up to the blocked output;
//  empty stages keep filling, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module perspective_divide_viewport_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  pdv_vtx_if.sink                     vtx,
  pdv_scr_if.source                   scr,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdv_pkg::APB_AW-1:0]  paddr,
  input  logic [pdv_pkg::APB_DW-1:0]  pwdata,
  output logic [pdv_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int NS = pdv_pkg::NSTAGE;
  localparam int QW = pdv_pkg::QUO_W;

  logic [NS-1:0]              v;
  logic [NS:0]                en;
  logic [pdv_pkg::SIZE_W-1:0] width;
  logic [pdv_pkg::SIZE_W-1:0] height;
  pdv_pkg::div_pipe_t         pipe [QW+1];

  // Stage advances when it is empty or the stage after it advances
  always_comb begin
    en[NS] = scr.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = en[i+1] | ~v[i];
    end
  end

  assign vtx.ready = en[0];
  assign scr.valid = v[NS-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= vtx.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  pdv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width   (width),
    .height  (height)
  );

  pdv_div_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .en     (en[0]),
    .clip_x (vtx.clip_x),
    .clip_y (vtx.clip_y),
    .clip_z (vtx.clip_z),
    .clip_w (vtx.clip_w),
    .q      (pipe[0])
  );

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    pdv_div_stage #(.FRAC_BITS(FRAC_BITS), .BIT(QW - 1 - k)) u_step (
      .clk (clk),
      .en  (en[k+1]),
      .d   (pipe[k]),
      .q   (pipe[k+1])
    );
  end

  pdv_map #(.FRAC_BITS(FRAC_BITS)) u_map (
    .clk       (clk),
    .en_sat    (en[QW+1]),
    .en_mul    (en[QW+2]),
    .en_out    (en[QW+3]),
    .d         (pipe[QW]),
    .width     (width),
    .height    (height),
    .screen_x  (scr.screen_x),
    .screen_y  (scr.screen_y),
    .ndc_depth (scr.ndc_depth),
    .w_zero    (scr.w_zero),
    .saturated (scr.saturated)
  );

endmodule
